// ===== hw/rtl/esqrt_pkg.sv =====
// esqrt_pkg: shared types, constants and the microcode program of the square root unit
// used by esqrt_seq, esqrt_dp and ieee754_square_root; no dependencies
`timescale 1ns / 1ps
package esqrt_pkg;

   localparam int StepWidth = 3;
   localparam int MantWidth = 54;   // room for hidden bit plus one parity shift
   localparam int ExpWidth  = 13;   // signed unbiased exponent
   localparam int RootWidth = 54;
   localparam int RemWidth  = 58;
   localparam int CntWidth  = 6;
   localparam int XWidth    = 106;  // two bits per root bit, 53 root bits

   localparam logic [ExpWidth-1:0] BiasSingle = 13'd127;
   localparam logic [ExpWidth-1:0] BiasDouble = 13'd1023;
   localparam logic [63:0] DnanSingle = 64'h0000_0000_7fc0_0000;
   localparam logic [63:0] DnanDouble = 64'h7ff8_0000_0000_0000;
   localparam logic [CntWidth-1:0] LastIterSingle = 6'd23;
   localparam logic [CntWidth-1:0] LastIterDouble = 6'd52;

   typedef logic [StepWidth-1:0] step_type;

   localparam step_type StepIdle   = 3'd0;
   localparam step_type StepUnpack = 3'd1;
   localparam step_type StepBranch = 3'd2;
   localparam step_type StepNorm   = 3'd3;
   localparam step_type StepAlign  = 3'd4;
   localparam step_type StepIter   = 3'd5;
   localparam step_type StepRound  = 3'd6;
   localparam step_type StepDone   = 3'd7;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_UNPACK = 3'd1,
      OP_NOP    = 3'd2,
      OP_NORM   = 3'd3,
      OP_ALIGN  = 3'd4,
      OP_ITER   = 3'd5,
      OP_ROUND  = 3'd6,
      OP_EMIT   = 3'd7
   } dp_op_type;

   typedef enum logic [2:0] {
      COND_NEXT        = 3'd0,
      COND_IF_NO_START = 3'd1,
      COND_IF_SPECIAL  = 3'd2,
      COND_IF_NOT_NORM = 3'd3,
      COND_IF_CNT_NZ   = 3'd4,
      COND_IF_OUT_BUSY = 3'd5
   } cond_type;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      step_type  target;
   } ctl_word_type;

   typedef struct packed {
      logic start;
      logic out_free;
      logic special;
      logic normed;
      logic cnt_nz;
   } status_type;

   // the program: one control word per step
   function automatic ctl_word_type ucode(input step_type s);
      ctl_word_type w;
      case (s)
         StepIdle:   w = '{OP_LOAD,   COND_IF_NO_START, StepIdle};
         StepUnpack: w = '{OP_UNPACK, COND_NEXT,        StepIdle};
         StepBranch: w = '{OP_NOP,    COND_IF_SPECIAL,  StepDone};
         StepNorm:   w = '{OP_NORM,   COND_IF_NOT_NORM, StepNorm};
         StepAlign:  w = '{OP_ALIGN,  COND_NEXT,        StepIdle};
         StepIter:   w = '{OP_ITER,   COND_IF_CNT_NZ,   StepIter};
         StepRound:  w = '{OP_ROUND,  COND_NEXT,        StepIdle};
         StepDone:   w = '{OP_EMIT,   COND_IF_OUT_BUSY, StepDone};
         default:    w = '{OP_NOP,    COND_NEXT,        StepIdle};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/esqrt_seq.sv =====
// esqrt_seq: step counter and microcode table with conditional jumps
// depends on esqrt_pkg
`timescale 1ns / 1ps
module esqrt_seq
   import esqrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  status_type   status,
   output ctl_word_type ctl
);

   step_type step_ff, step_in;
   logic     take;

   assign ctl = ucode(step_ff);

   always_comb begin
      case (ctl.cond)
         COND_NEXT:        take = 1'b0;
         COND_IF_NO_START: take = !status.start;
         COND_IF_SPECIAL:  take = status.special;
         COND_IF_NOT_NORM: take = !status.normed;
         COND_IF_CNT_NZ:   take = status.cnt_nz;
         COND_IF_OUT_BUSY: take = !status.out_free;
         default:          take = 1'b0;
      endcase
      // the done step wraps back to idle
      step_in = take ? ctl.target : step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= StepIdle;
      end else begin
         step_ff <= step_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_start_unpacks: assert property (@(posedge clock) disable iff (reset)
      (step_ff == StepIdle && status.start) |=> step_ff == StepUnpack)
      else $error("accepted item did not start unpack");
   a_align_iter: assert property (@(posedge clock) disable iff (reset)
      step_ff == StepAlign |=> step_ff == StepIter)
      else $error("align not followed by recurrence");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step_ff == StepDone && status.out_free) |=> step_ff == StepIdle)
      else $error("emitted item did not return to idle");
`endif

endmodule

// ===== hw/rtl/esqrt_dp.sv =====
// esqrt_dp: unpack, normalize, radix-2 restoring recurrence, round and pack
// depends on esqrt_pkg; driven by the control word of esqrt_seq
`timescale 1ns / 1ps
module esqrt_dp
   import esqrt_pkg::*;
(
   input  logic         clock,
   input  dp_op_type    op_code,
   input  logic         start,
   input  logic         in_op,
   input  logic [63:0]  in_operand_bits,
   output logic         special,
   output logic         normed,
   output logic         cnt_nz,
   output logic [63:0]  result
);

   logic                 dbl_ff;
   logic [63:0]          x_ff;
   logic                 special_ff;
   logic [63:0]          result_ff;
   logic [MantWidth-1:0] m_ff;
   logic [ExpWidth-1:0]  u_ff;
   logic [XWidth-1:0]    pairs_ff;
   logic [RootWidth-1:0] root_ff;
   logic [RemWidth-1:0]  rem_ff;
   logic [CntWidth-1:0]  cnt_ff;

   // unpack
   logic        sgn;
   logic [10:0] e;
   logic [10:0] emax;
   logic [51:0] f;
   logic [63:0] qbit, dnan;
   logic [ExpWidth-1:0] bias;
   logic        e_max, e_zero, f_zero;

   always_comb begin
      sgn    = dbl_ff ? x_ff[63] : x_ff[31];
      e      = dbl_ff ? x_ff[62:52] : {3'b0, x_ff[30:23]};
      f      = dbl_ff ? x_ff[51:0] : {29'b0, x_ff[22:0]};
      emax   = dbl_ff ? 11'h7ff : 11'h0ff;
      qbit   = dbl_ff ? 64'h0008_0000_0000_0000 : 64'h0000_0000_0040_0000;
      dnan   = dbl_ff ? DnanDouble : DnanSingle;
      bias   = dbl_ff ? BiasDouble : BiasSingle;
      e_max  = (e == emax);
      e_zero = (e == 11'd0);
      f_zero = (f == 52'd0);
   end

   assign normed = dbl_ff ? m_ff[52] : m_ff[23];

   // parity alignment and placement of the first digit pair at the top
   logic [MantWidth-1:0] m_al;
   logic [ExpWidth-1:0]  u_al;
   logic [XWidth-1:0]    pairs_al;

   always_comb begin
      m_al = u_ff[0] ? {m_ff[MantWidth-2:0], 1'b0} : m_ff;
      u_al = u_ff[0] ? u_ff - 13'd1 : u_ff;
      pairs_al = dbl_ff ? {m_al, 52'b0} : {m_al[24:0], 81'b0};
   end

   // one recurrence step
   logic [RemWidth-1:0]  rem_sh, trial;
   logic [RootWidth-1:0] root_sh;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff[RemWidth-3:0], pairs_ff[XWidth-1:XWidth-2]};
      root_sh = {root_ff[RootWidth-2:0], 1'b0};
      trial   = {2'b0, root_ff, 2'b01};
      ge      = (rem_sh >= trial);
   end

   // rounding and packing
   logic [RootWidth-1:0] root_r, root_f;
   logic                 carry;
   logic [ExpWidth-1:0]  ef;

   always_comb begin
      root_r = root_ff + {{(RootWidth-1){1'b0}}, (rem_ff > {4'b0, root_ff})};
      carry  = dbl_ff ? root_r[53] : root_r[24];
      root_f = carry ? {1'b0, root_r[RootWidth-1:1]} : root_r;
      ef     = {u_ff[ExpWidth-1], u_ff[ExpWidth-1:1]} + bias
               + {{(ExpWidth-1){1'b0}}, carry};
   end

   always_ff @(posedge clock) begin
      case (op_code)
         OP_LOAD: begin
            if (start) begin
               dbl_ff <= in_op;
               x_ff   <= in_op ? in_operand_bits : {32'b0, in_operand_bits[31:0]};
            end
         end
         OP_UNPACK: begin
            special_ff <= e_max || (e_zero && f_zero) || sgn;
            if (e_max) begin
               result_ff <= !f_zero ? (x_ff | qbit) : (sgn ? dnan : x_ff);
            end else if (e_zero && f_zero) begin
               result_ff <= x_ff;
            end else begin
               result_ff <= dnan;
            end
            if (!e_zero) begin
               m_ff <= dbl_ff ? {1'b0, 1'b1, f} : {30'b0, 1'b1, f[22:0]};
               u_ff <= {2'b0, e} - bias;
            end else begin
               m_ff <= {2'b0, f};
               u_ff <= 13'd1 - bias;
            end
         end
         OP_NORM: begin
            if (!normed) begin
               m_ff <= {m_ff[MantWidth-2:0], 1'b0};
               u_ff <= u_ff - 13'd1;
            end
         end
         OP_ALIGN: begin
            u_ff     <= u_al;
            pairs_ff <= pairs_al;
            root_ff  <= '0;
            rem_ff   <= '0;
            cnt_ff   <= dbl_ff ? LastIterDouble : LastIterSingle;
         end
         OP_ITER: begin
            pairs_ff <= {pairs_ff[XWidth-3:0], 2'b00};
            rem_ff   <= ge ? rem_sh - trial : rem_sh;
            root_ff  <= root_sh | {{(RootWidth-1){1'b0}}, ge};
            cnt_ff   <= cnt_ff - 6'd1;
         end
         OP_ROUND: begin
            result_ff <= dbl_ff ? {1'b0, ef[10:0], root_f[51:0]}
                                : {33'b0, ef[7:0], root_f[22:0]};
         end
         default: begin
         end
      endcase
   end

   assign special = special_ff;
   assign cnt_nz  = (cnt_ff != 6'd0);
   assign result  = result_ff;

endmodule

// ===== hw/rtl/ieee754_square_root.sv =====
// ieee754_square_root: single/double square root, round to nearest even
// subnormal operands are first shifted left in the normalize step until the hidden bit is set;
// NaN, infinity, zero and negative operands skip normalization, recurrence and rounding
// a new item is taken only in the idle step, after the previous result is registered
// the recurrence makes one root bit per cycle
// the result register lets the next item start while a result waits
// reset (synchronous, active high) clears the step counter and rsp_valid
`timescale 1ns / 1ps
module ieee754_square_root
   import esqrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [63:0] req_operand_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_root_bits
);

   ctl_word_type ctl;
   status_type   status;
   logic         special, normed, cnt_nz;
   logic [63:0]  result;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  root_ff;
   logic         out_free, emit;

   assign req_stall = (ctl.op != OP_LOAD);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (ctl.op == OP_EMIT) && out_free;

   assign status = '{start:    req_valid && !req_stall,
                     out_free: out_free,
                     special:  special,
                     normed:   normed,
                     cnt_nz:   cnt_nz};

   esqrt_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   esqrt_dp u_dp (
      .clock           (clock),
      .op_code         (ctl.op),
      .start           (status.start),
      .in_op           (req_op),
      .in_operand_bits (req_operand_bits),
      .special         (special),
      .normed          (normed),
      .cnt_nz          (cnt_nz),
      .result          (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         root_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root_bits = root_ff;

endmodule
